/* hdl/efrc_pkg.sv */
package efrc_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 1500;
    localparam int MIN_PAYLOAD_DEFAULT = 46;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [10:0] INDEX_MAX    = 11'h7FF;
    localparam logic [10:0] PREAMBLE_LEN = 11'd7;
    localparam logic [10:0] SFD_POS      = 11'd7;
    localparam logic [10:0] OUTER_HI_POS = 11'd20;
    localparam logic [10:0] OUTER_LO_POS = 11'd21;
    localparam logic [10:0] TAG_HI_POS   = 11'd22;
    localparam logic [10:0] TAG_LO_POS   = 11'd23;
    localparam logic [10:0] INNER_HI_POS = 11'd24;
    localparam logic [10:0] INNER_LO_POS = 11'd25;
    localparam logic [10:0] CRC_START    = 11'd12;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0]  SFD_BYTE      = 8'hD5;
    localparam logic [15:0] TYPE_VLAN     = 16'h8100;
    localparam logic [15:0] TYPE_MIN      = 16'h0600;
    localparam logic [11:0] BASE_BYTES    = 12'd26;
    localparam logic [11:0] TAG_BYTES     = 12'd4;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

    typedef struct packed {
        logic        start_good;
        logic [11:0] count;
        logic [15:0] outer_type;
        logic [15:0] tag_control;
        logic [15:0] inner_type;
        logic [31:0] crc;
        logic [31:0] fcs;
    } frame_sum_t;

    typedef struct packed {
        logic        frame_ok;
        logic        frame_format;
        logic        vlan_tagged;
        logic [2:0]  vlan_priority;
        logic        vlan_dei;
        logic [11:0] vlan_ident;
        logic [15:0] type_or_len;
        logic [10:0] client_length;
        logic [10:0] payload_length;
    } frame_res_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hdl/efrc_front.sv */
module efrc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    output logic                 sum_push,
    output efrc_pkg::frame_sum_t sum_data
);
    import efrc_pkg::*;

    logic [10:0]      index_reg, index_next;
    logic             good_reg, good_next;
    logic [15:0]      outer_reg, outer_next;
    logic [15:0]      tag_reg, tag_next;
    logic [15:0]      inner_reg, inner_next;
    logic [31:0]      crc_reg, crc_next;
    logic [3:0][7:0]  fcs_reg, fcs_next;
    logic             good_c;
    logic [15:0]      outer_c, tag_c, inner_c;
    logic [31:0]      crc_c;
    logic [3:0][7:0]  fcs_c;

    always_comb
    begin
        good_c  = good_reg;
        outer_c = outer_reg;
        tag_c   = tag_reg;
        inner_c = inner_reg;
        crc_c   = crc_reg;
        if (index_reg < PREAMBLE_LEN)
        begin
            if (rx_byte != PREAMBLE_BYTE)
                good_c = 1'b0;
        end
        else if (index_reg == SFD_POS)
        begin
            if (rx_byte != SFD_BYTE)
                good_c = 1'b0;
        end
        if (index_reg == OUTER_HI_POS) outer_c[15:8] = rx_byte;
        if (index_reg == OUTER_LO_POS) outer_c[7:0]  = rx_byte;
        if (index_reg == TAG_HI_POS)   tag_c[15:8]   = rx_byte;
        if (index_reg == TAG_LO_POS)   tag_c[7:0]    = rx_byte;
        if (index_reg == INNER_HI_POS) inner_c[15:8] = rx_byte;
        if (index_reg == INNER_LO_POS) inner_c[7:0]  = rx_byte;
        if (index_reg >= CRC_START)
            crc_c = crc_byte(crc_reg, fcs_reg[3]);
        fcs_c = {fcs_reg[2], fcs_reg[1], fcs_reg[0], rx_byte};

        sum_push             = take && frame_end;
        sum_data.start_good  = good_c;
        sum_data.count       = {1'b0, index_reg} + 12'd1;
        sum_data.outer_type  = outer_c;
        sum_data.tag_control = tag_c;
        sum_data.inner_type  = inner_c;
        sum_data.crc         = crc_c;
        sum_data.fcs         = {fcs_c[0], fcs_c[1], fcs_c[2], fcs_c[3]};

        index_next = index_reg;
        good_next  = good_reg;
        outer_next = outer_reg;
        tag_next   = tag_reg;
        inner_next = inner_reg;
        crc_next   = crc_reg;
        fcs_next   = fcs_reg;
        if (take)
        begin
            if (frame_end)
            begin
                index_next = '0;
                good_next  = 1'b1;
                outer_next = '0;
                tag_next   = '0;
                inner_next = '0;
                crc_next   = CRC_INIT;
                fcs_next   = '0;
            end
            else
            begin
                index_next = (index_reg < INDEX_MAX) ? index_reg + 11'd1 : index_reg;
                good_next  = good_c;
                outer_next = outer_c;
                tag_next   = tag_c;
                inner_next = inner_c;
                crc_next   = crc_c;
                fcs_next   = fcs_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            good_reg  <= 1'b1;
            outer_reg <= '0;
            tag_reg   <= '0;
            inner_reg <= '0;
            crc_reg   <= CRC_INIT;
            fcs_reg   <= '0;
        end
        else
        begin
            index_reg <= index_next;
            good_reg  <= good_next;
            outer_reg <= outer_next;
            tag_reg   <= tag_next;
            inner_reg <= inner_next;
            crc_reg   <= crc_next;
            fcs_reg   <= fcs_next;
        end
    end

endmodule

/* hdl/efrc_queue.sv */
module efrc_queue #(
    parameter int DEPTH = efrc_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  efrc_pkg::frame_sum_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output efrc_pkg::frame_sum_t head_data
);
    import efrc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_sum_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* hdl/efrc_back.sv */
module efrc_back #(
    parameter int MAX_PAYLOAD = efrc_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int MIN_PAYLOAD = efrc_pkg::MIN_PAYLOAD_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  efrc_pkg::frame_sum_t head_data,
    output logic                 head_pop,
    output logic                 empty,
    input  logic                 pop,
    output efrc_pkg::frame_res_t res
);
    import efrc_pkg::*;

    localparam logic [15:0] MAX16 = 16'(MAX_PAYLOAD);
    localparam logic [15:0] MIN16 = 16'(MIN_PAYLOAD);
    localparam logic [11:0] MAX12 = 12'(MAX_PAYLOAD);
    localparam logic [11:0] MIN12 = 12'(MIN_PAYLOAD);

    logic        out_valid_reg, out_valid_next;
    frame_res_t  res_reg, res_next;
    logic        has_tag;
    logic [11:0] hdr_len;
    logic [15:0] kind;
    logic [15:0] pad_len;
    logic [11:0] eth_len;
    logic        ok;

    always_comb
    begin
        has_tag = (head_data.outer_type == TYPE_VLAN);
        hdr_len = BASE_BYTES + (has_tag ? TAG_BYTES : 12'd0);
        kind    = has_tag ? head_data.inner_type : head_data.outer_type;
        pad_len = (kind < MIN16) ? MIN16 : kind;
        eth_len = (head_data.count >= hdr_len) ? head_data.count - hdr_len : 12'd0;
        ok      = head_data.start_good && (head_data.count >= hdr_len);

        res_next.frame_format   = 1'b0;
        res_next.client_length  = '0;
        res_next.payload_length = '0;
        priority if (kind <= MAX16)
        begin
            res_next.client_length  = kind[10:0];
            res_next.payload_length = pad_len[10:0];
            if (head_data.count != hdr_len + pad_len[11:0])
                ok = 1'b0;
        end
        else if (kind >= TYPE_MIN)
        begin
            res_next.frame_format   = 1'b1;
            res_next.client_length  = eth_len[10:0];
            res_next.payload_length = eth_len[10:0];
            if (eth_len < MIN12 || eth_len > MAX12)
                ok = 1'b0;
        end
        else
        begin
            ok = 1'b0;
        end
        if ((head_data.crc ^ CRC_INIT) != head_data.fcs)
            ok = 1'b0;

        res_next.frame_ok      = ok;
        res_next.vlan_tagged   = has_tag;
        res_next.vlan_priority = has_tag ? head_data.tag_control[15:13] : 3'd0;
        res_next.vlan_dei      = has_tag ? head_data.tag_control[12] : 1'b0;
        res_next.vlan_ident    = has_tag ? head_data.tag_control[11:0] : 12'd0;
        res_next.type_or_len   = kind;

        head_pop       = head_valid && (!out_valid_reg || pop);
        out_valid_next = head_pop ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
            res_reg <= res_next;
    end

    assign empty = !out_valid_reg;
    assign res   = res_reg;

endmodule

/* hdl/ethernet_frame_receive_checker.sv */
// Ethernet frame receive checker.
// Input queue side: one frame byte per transfer (rx_byte), preamble first, with
// frame_end high on the last FCS byte. A transfer happens when push is high and
// full is low. Output queue side: one summary result per frame, held on the
// result ports while empty is low and taken when pop is high.
// The front stage checks preamble/SFD, captures type and VLAN tag fields and
// runs the CRC-32 at one byte per cycle while full is low; the frame summary
// enters a two-entry queue, and the back stage classifies it into a registered
// result. Throughput: one byte per cycle, and one result per cycle even for
// frames of a single byte, while pop keeps up. The summary is queued on the
// last byte's transfer; empty falls when it reaches the output register.
// When the receiver stops popping, results fill the output register and the
// queue; full then rises and bytes are held off until a result is taken.
// Reset clears the byte counter, the captured fields, the queue pointers and
// count and presets the CRC; the block then waits for the first preamble byte.
module ethernet_frame_receive_checker #(
    parameter int MAX_PAYLOAD = efrc_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int MIN_PAYLOAD = efrc_pkg::MIN_PAYLOAD_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        frame_ok,
    output logic        frame_format,
    output logic        vlan_tagged,
    output logic [2:0]  vlan_priority,
    output logic        vlan_dei,
    output logic [11:0] vlan_ident,
    output logic [15:0] type_or_len,
    output logic [10:0] client_length,
    output logic [10:0] payload_length
);
    import efrc_pkg::*;

    logic       take;
    logic       sum_push;
    frame_sum_t sum_data;
    logic       head_valid;
    frame_sum_t head_data;
    logic       head_pop;
    frame_res_t res;

    assign take = push && !full;

    efrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .sum_push  (sum_push),
        .sum_data  (sum_data)
    );

    efrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (sum_push),
        .push_data  (sum_data),
        .full       (full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    efrc_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MIN_PAYLOAD (MIN_PAYLOAD)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .res        (res)
    );

    assign frame_ok       = res.frame_ok;
    assign frame_format   = res.frame_format;
    assign vlan_tagged    = res.vlan_tagged;
    assign vlan_priority  = res.vlan_priority;
    assign vlan_dei       = res.vlan_dei;
    assign vlan_ident     = res.vlan_ident;
    assign type_or_len    = res.type_or_len;
    assign client_length  = res.client_length;
    assign payload_length = res.payload_length;

endmodule
